/* hw/rtl/psd_pkg.sv */
// Shared widths, types and helpers for the point-to-segment distance pipeline.
package psd_pkg;

  localparam int CW        = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 32;
  localparam int DIST_W    = 32;
  localparam int MW        = CW;
  localparam int PW        = 2 * MW;
  localparam int SW        = PW + 2;
  localparam int HW        = SW / 2;
  localparam int NW        = 2 * SW;
  localparam int RW        = NW + 2;
  localparam int ROOT_STEPS = DIST_W;

  localparam int TWOF  = 2 * FRAC_BITS;
  localparam int UP_SH = (TWOF >= CFG_W) ? (TWOF - CFG_W) : 0;
  localparam int DN_SH = (TWOF >= CFG_W) ? 0 : (CFG_W - TWOF);

  localparam logic [CFG_W-1:0] MSL_RESET = 32'd429497;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [MW-1:0]        mag_t;
  typedef logic [PW-1:0]        prod_t;
  typedef logic [SW-1:0]        sq_t;
  typedef logic [2*HW-1:0]      pp_t;
  typedef logic [NW-1:0]        num_t;
  typedef logic [RW-1:0]        rem_t;
  typedef logic [DIST_W-1:0]    dist_t;

  typedef struct packed {
    logic valid;
    logic degen;
    logic proj;
    sq_t  simple;
    sq_t  dm;
    sq_t  len2;
    sq_t  w2;
  } cls_t;

  typedef struct packed {
    logic valid;
    logic degen;
    num_t num;
    sq_t  den;
  } frac_t;

  // Threshold rescaled from 32 fraction bits to 2*FRAC_BITS, rounding up.
  function automatic sq_t scale_thr(input logic [CFG_W-1:0] msl);
    sq_t x;
    x = sq_t'(msl);
    if (TWOF >= CFG_W) begin
      return x << UP_SH;
    end else begin
      return (x + ((sq_t'(1) << DN_SH) - sq_t'(1))) >> DN_SH;
    end
  endfunction

endpackage

/* hw/rtl/psd_front.sv */
// Front stages: differences, squares and dot terms, sums, case classification.
module psd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  input  psd_pkg::coord_t       q_i [3],
  input  psd_pkg::coord_t       s_i [3],
  input  psd_pkg::coord_t       e_i [3],
  input  psd_pkg::sq_t          thr_i,
  output psd_pkg::cls_t         cls_o
);

  // stage 1: component differences as magnitude and sign
  logic            v1_r, v1_nxt;
  psd_pkg::mag_t   um_r [3], um_nxt [3];
  psd_pkg::mag_t   sm_r [3], sm_nxt [3];
  psd_pkg::mag_t   vm_r [3], vm_nxt [3];
  logic [2:0]      xs_r, xs_nxt;

  always_comb begin
    logic signed [psd_pkg::CW:0] du, ds, dv;
    v1_nxt = valid_i;
    for (int i = 0; i < 3; i++) begin
      du = {q_i[i][psd_pkg::CW-1], q_i[i]} - {s_i[i][psd_pkg::CW-1], s_i[i]};
      ds = {e_i[i][psd_pkg::CW-1], e_i[i]} - {s_i[i][psd_pkg::CW-1], s_i[i]};
      dv = {q_i[i][psd_pkg::CW-1], q_i[i]} - {e_i[i][psd_pkg::CW-1], e_i[i]};
      um_nxt[i] = du[psd_pkg::CW] ? psd_pkg::mag_t'(-du) : psd_pkg::mag_t'(du);
      sm_nxt[i] = ds[psd_pkg::CW] ? psd_pkg::mag_t'(-ds) : psd_pkg::mag_t'(ds);
      vm_nxt[i] = dv[psd_pkg::CW] ? psd_pkg::mag_t'(-dv) : psd_pkg::mag_t'(dv);
      xs_nxt[i] = du[psd_pkg::CW] ^ ds[psd_pkg::CW];
    end
  end

  // stage 2: products
  logic            v2_r, v2_nxt;
  psd_pkg::prod_t  uu_r [3], uu_nxt [3];
  psd_pkg::prod_t  ss_r [3], ss_nxt [3];
  psd_pkg::prod_t  vv_r [3], vv_nxt [3];
  psd_pkg::prod_t  us_r [3], us_nxt [3];
  logic [2:0]      xs2_r, xs2_nxt;

  always_comb begin
    v2_nxt  = v1_r;
    xs2_nxt = xs_r;
    for (int i = 0; i < 3; i++) begin
      uu_nxt[i] = um_r[i] * um_r[i];
      ss_nxt[i] = sm_r[i] * sm_r[i];
      vv_nxt[i] = vm_r[i] * vm_r[i];
      us_nxt[i] = um_r[i] * sm_r[i];
    end
  end

  // stage 3: sums
  logic          v3_r, v3_nxt;
  psd_pkg::sq_t  w2_r, w2_nxt, len2_r, len2_nxt, vq_r, vq_nxt;
  psd_pkg::sq_t  pos_r, pos_nxt, neg_r, neg_nxt;

  always_comb begin
    v3_nxt   = v2_r;
    w2_nxt   = '0;
    len2_nxt = '0;
    vq_nxt   = '0;
    pos_nxt  = '0;
    neg_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      w2_nxt   = w2_nxt   + psd_pkg::sq_t'(uu_r[i]);
      len2_nxt = len2_nxt + psd_pkg::sq_t'(ss_r[i]);
      vq_nxt   = vq_nxt   + psd_pkg::sq_t'(vv_r[i]);
      pos_nxt  = pos_nxt  + (xs2_r[i] ? '0 : psd_pkg::sq_t'(us_r[i]));
      neg_nxt  = neg_nxt  + (xs2_r[i] ? psd_pkg::sq_t'(us_r[i]) : '0);
    end
  end

  // stage 4: which of the four cases applies
  psd_pkg::cls_t cls_r, cls_nxt;

  always_comb begin
    logic         degen, pre_start, beyond;
    psd_pkg::sq_t dm;
    degen     = len2_r < thr_i;
    pre_start = pos_r <= neg_r;
    dm        = pos_r - neg_r;
    beyond    = dm >= len2_r;
    cls_nxt.valid  = v3_r;
    cls_nxt.degen  = degen;
    cls_nxt.proj   = !degen && !pre_start && !beyond;
    cls_nxt.simple = (!degen && !pre_start && beyond) ? vq_r : w2_r;
    cls_nxt.dm     = dm;
    cls_nxt.len2   = len2_r;
    cls_nxt.w2     = w2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      cls_r <= '0;
    end else begin
      v1_r  <= v1_nxt;
      v2_r  <= v2_nxt;
      v3_r  <= v3_nxt;
      cls_r <= cls_nxt;
    end
  end

  always_ff @(posedge clk) begin
    um_r   <= um_nxt;
    sm_r   <= sm_nxt;
    vm_r   <= vm_nxt;
    xs_r   <= xs_nxt;
    uu_r   <= uu_nxt;
    ss_r   <= ss_nxt;
    vv_r   <= vv_nxt;
    us_r   <= us_nxt;
    xs2_r  <= xs2_nxt;
    w2_r   <= w2_nxt;
    len2_r <= len2_nxt;
    vq_r   <= vq_nxt;
    pos_r  <= pos_nxt;
    neg_r  <= neg_nxt;
  end

  assign cls_o = cls_r;

  a_proj_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cls_r.valid && cls_r.proj |-> !cls_r.degen && cls_r.dm != '0 && cls_r.dm < cls_r.len2)
    else $error("projection case with inconsistent dot term");

endmodule

/* hw/rtl/psd_numer.sv */
// Middle stages: numerator w2*len2 - dm^2 over len2 from split partial products, else simple over one.
module psd_numer (
  input  logic           clk,
  input  logic           rst_n,
  input  psd_pkg::cls_t  cls_i,
  output psd_pkg::frac_t frac_o
);

  localparam int HW = psd_pkg::HW;
  localparam int SW = psd_pkg::SW;

  // stage 5: partial products on half words
  logic          v5_r, v5_nxt, dg5_r, dg5_nxt, pj5_r, pj5_nxt;
  psd_pkg::sq_t  sim5_r, sim5_nxt, len5_r, len5_nxt;
  psd_pkg::pp_t  p00_r, p01_r, p10_r, p11_r, p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  psd_pkg::pp_t  q00_r, q01_r, q11_r, q00_nxt, q01_nxt, q11_nxt;

  always_comb begin
    logic [HW-1:0] wl, wh, ll, lh, dl, dh;
    wl = cls_i.w2[HW-1:0];
    wh = cls_i.w2[SW-1:HW];
    ll = cls_i.len2[HW-1:0];
    lh = cls_i.len2[SW-1:HW];
    dl = cls_i.dm[HW-1:0];
    dh = cls_i.dm[SW-1:HW];
    v5_nxt   = cls_i.valid;
    dg5_nxt  = cls_i.degen;
    pj5_nxt  = cls_i.proj;
    sim5_nxt = cls_i.simple;
    len5_nxt = cls_i.len2;
    p00_nxt  = wl * ll;
    p01_nxt  = wl * lh;
    p10_nxt  = wh * ll;
    p11_nxt  = wh * lh;
    q00_nxt  = dl * dl;
    q01_nxt  = dl * dh;
    q11_nxt  = dh * dh;
  end

  // stage 6: assemble the two full products
  logic          v6_r, v6_nxt, dg6_r, dg6_nxt, pj6_r, pj6_nxt;
  psd_pkg::sq_t  sim6_r, sim6_nxt, len6_r, len6_nxt;
  psd_pkg::num_t a6_r, a6_nxt, b6_r, b6_nxt;

  always_comb begin
    v6_nxt   = v5_r;
    dg6_nxt  = dg5_r;
    pj6_nxt  = pj5_r;
    sim6_nxt = sim5_r;
    len6_nxt = len5_r;
    a6_nxt   = psd_pkg::num_t'(p00_r)
             + ((psd_pkg::num_t'(p01_r) + psd_pkg::num_t'(p10_r)) << HW)
             + (psd_pkg::num_t'(p11_r) << SW);
    b6_nxt   = psd_pkg::num_t'(q00_r)
             + (psd_pkg::num_t'(q01_r) << (HW + 1))
             + (psd_pkg::num_t'(q11_r) << SW);
  end

  // stage 7: pick numerator and denominator
  psd_pkg::frac_t fr_r, fr_nxt;

  always_comb begin
    fr_nxt.valid = v6_r;
    fr_nxt.degen = dg6_r;
    if (pj6_r) begin
      fr_nxt.num = (a6_r >= b6_r) ? (a6_r - b6_r) : '0;
      fr_nxt.den = len6_r;
    end else begin
      fr_nxt.num = psd_pkg::num_t'(sim6_r);
      fr_nxt.den = psd_pkg::sq_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      fr_r <= '0;
    end else begin
      v5_r <= v5_nxt;
      v6_r <= v6_nxt;
      fr_r <= fr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dg5_r  <= dg5_nxt;
    pj5_r  <= pj5_nxt;
    sim5_r <= sim5_nxt;
    len5_r <= len5_nxt;
    p00_r  <= p00_nxt;
    p01_r  <= p01_nxt;
    p10_r  <= p10_nxt;
    p11_r  <= p11_nxt;
    q00_r  <= q00_nxt;
    q01_r  <= q01_nxt;
    q11_r  <= q11_nxt;
    dg6_r  <= dg6_nxt;
    pj6_r  <= pj6_nxt;
    sim6_r <= sim6_nxt;
    len6_r <= len6_nxt;
    a6_r   <= a6_nxt;
    b6_r   <= b6_nxt;
  end

  assign frac_o = fr_r;

  // Cauchy-Schwarz: dot^2 never exceeds |u|^2 |d|^2
  a_cs: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && pj6_r |-> a6_r >= b6_r)
    else $error("negative projection numerator");

  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    fr_r.valid |-> fr_r.den != '0)
    else $error("zero denominator");

endmodule

/* hw/rtl/psd_root.sv */
// Back stages: one result bit per stage of floor(sqrt(num / den)).
module psd_root (
  input  logic            clk,
  input  logic            rst_n,
  input  psd_pkg::frac_t  frac_i,
  output logic            valid_o,
  output psd_pkg::dist_t  dist_o,
  output logic            degen_o
);

  localparam int L = psd_pkg::ROOT_STEPS;

  logic            v_in  [L], v_r  [L];
  logic            dg_in [L], dg_r [L];
  psd_pkg::rem_t   r_in  [L], r_r  [L];
  psd_pkg::rem_t   t_in  [L], t_r  [L];
  psd_pkg::sq_t    d_in  [L], d_r  [L];
  psd_pkg::dist_t  n_in  [L], n_r  [L];

  for (genvar k = 0; k < L; k++) begin : g_step
    localparam int B = L - 1 - k;
    psd_pkg::rem_t  delta, r_nxt, t_nxt;
    psd_pkg::dist_t n_nxt;
    logic           fit;

    if (k == 0) begin : g_head
      assign v_in[k]  = frac_i.valid;
      assign dg_in[k] = frac_i.degen;
      assign r_in[k]  = psd_pkg::rem_t'(frac_i.num);
      assign t_in[k]  = '0;
      assign d_in[k]  = frac_i.den;
      assign n_in[k]  = '0;
    end else begin : g_link
      assign v_in[k]  = v_r[k-1];
      assign dg_in[k] = dg_r[k-1];
      assign r_in[k]  = r_r[k-1];
      assign t_in[k]  = t_r[k-1];
      assign d_in[k]  = d_r[k-1];
      assign n_in[k]  = n_r[k-1];
    end

    // (n + 2^B)^2 den - n^2 den = (n den) 2^(B+1) + den 2^(2B)
    always_comb begin
      delta = (t_in[k] << (B + 1)) + (psd_pkg::rem_t'(d_in[k]) << (2 * B));
      fit   = delta <= r_in[k];
      r_nxt = fit ? (r_in[k] - delta) : r_in[k];
      t_nxt = fit ? (t_in[k] + (psd_pkg::rem_t'(d_in[k]) << B)) : t_in[k];
      n_nxt = fit ? (n_in[k] | (psd_pkg::dist_t'(1) << B)) : n_in[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      dg_r[k] <= dg_in[k];
      r_r[k]  <= r_nxt;
      t_r[k]  <= t_nxt;
      d_r[k]  <= d_in[k];
      n_r[k]  <= n_nxt;
    end
  end

  assign valid_o = v_r[L-1];
  assign dist_o  = n_r[L-1];
  assign degen_o = dg_r[L-1];

  // the next integer root would overshoot unless saturated
  a_root_max: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L-1] && n_r[L-1] != '1 |->
      ((t_r[L-1] << 1) + psd_pkg::rem_t'(d_r[L-1])) > r_r[L-1])
    else $error("root not maximal");

  a_root_tn: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L-1] && n_r[L-1] == '0 |-> t_r[L-1] == '0)
    else $error("root product out of step");

endmodule

/* hw/rtl/point_segment_distance_3d.sv */
// Top level: 3D point-to-segment distance, Q16.16 in, Q16.16 distance out.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------------
//  input    | in_query_*, in_start_*, in_end_*        | beat when start && !busy
//  result   | out_distance, out_degenerate            | beat when out_valid
//  config   | cfg_wdata                               | write when cfg_we
//
//  One beat is accepted every cycle; busy is always low.
//  The pipeline runs through 4 front stages (differences, products, sums, case select),
//  3 numerator stages (half-word partial products, assembly, select), and
//  32 square-root stages, one result bit each.
//  Synchronous active-low reset clears all valid bits and loads the threshold.
//  The receiver cannot stall; every result is shown for exactly one cycle.
module point_segment_distance_3d (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          in_query_x,
  input  logic signed [31:0]          in_query_y,
  input  logic signed [31:0]          in_query_z,
  input  logic signed [31:0]          in_start_x,
  input  logic signed [31:0]          in_start_y,
  input  logic signed [31:0]          in_start_z,
  input  logic signed [31:0]          in_end_x,
  input  logic signed [31:0]          in_end_y,
  input  logic signed [31:0]          in_end_z,
  output logic                        out_valid,
  output logic [31:0]                 out_distance,
  output logic                        out_degenerate,
  input  logic                        cfg_we,
  input  logic [31:0]                 cfg_wdata
);

  logic [psd_pkg::CFG_W-1:0] msl_r, msl_nxt;
  psd_pkg::coord_t           q [3], s [3], e [3];
  psd_pkg::cls_t             cls;
  psd_pkg::frac_t            frac;
  psd_pkg::dist_t            root_dist;

  assign busy = 1'b0;

  assign msl_nxt = cfg_we ? cfg_wdata : msl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msl_r <= psd_pkg::MSL_RESET;
    end else begin
      msl_r <= msl_nxt;
    end
  end

  assign q[0] = in_query_x;
  assign q[1] = in_query_y;
  assign q[2] = in_query_z;
  assign s[0] = in_start_x;
  assign s[1] = in_start_y;
  assign s[2] = in_start_z;
  assign e[0] = in_end_x;
  assign e[1] = in_end_y;
  assign e[2] = in_end_z;

  psd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .q_i     (q),
    .s_i     (s),
    .e_i     (e),
    .thr_i   (psd_pkg::scale_thr(msl_r)),
    .cls_o   (cls)
  );

  psd_numer u_numer (
    .clk    (clk),
    .rst_n  (rst_n),
    .cls_i  (cls),
    .frac_o (frac)
  );

  psd_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .frac_i  (frac),
    .valid_o (out_valid),
    .dist_o  (root_dist),
    .degen_o (out_degenerate)
  );

  assign out_distance = root_dist;

endmodule
